[rtl/tlb_tf_pkg.sv]
// ----------------------------------------------------------------------------
// TLB translate package
// Shared types and constants for the translation buffer.
// ----------------------------------------------------------------------------
`default_nettype none
package tlb_tf_pkg;

  localparam logic [2:0] StHit       = 3'd0;
  localparam logic [2:0] StMiss      = 3'd1;
  localparam logic [2:0] StFilled    = 3'd2;
  localparam logic [2:0] StWalkErr   = 3'd3;
  localparam logic [2:0] StNoPending = 3'd4;

  localparam logic [2:0] RegPid    = 3'd0;
  localparam logic [2:0] RegInUse  = 3'd1;
  localparam logic [2:0] RegPolicy = 3'd2;
  localparam logic [2:0] RegPsl    = 3'd3;
  localparam logic [2:0] RegTel    = 3'd4;
  localparam logic [2:0] RegLevels = 3'd5;

  localparam int unsigned PageW = 28;
  localparam int unsigned PidW  = 16;
  localparam int unsigned StampW = 32;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_PICK  = 5'b00100,
    S_WRITE = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

endpackage : tlb_tf_pkg
`default_nettype wire

[rtl/tlb_translate_fifo_lru_unit.sv]
// ----------------------------------------------------------------------------
// TLB translate unit
// Fully associative process-tagged TLB with FIFO or LRU replacement.
// ----------------------------------------------------------------------------
// One item is handled at a time. The entry memory is scanned one slot per
// cycle through its single read port, over n slots, n being entries_in_use
// saturated to the depth. A miss scans all n slots; a hit stops at its slot
// and writes back the use stamp; a fill scans all n, picks a slot and writes
// it (no write with no entries enabled). A fill with nothing pending or a
// walk error answers in the next cycle. The result sits in an output
// register; the next item is accepted in the cycle after it has been taken.
`default_nettype none
module tlb_translate_fifo_lru_unit #(
  parameter int unsigned TLB_DEPTH  = 16,
  parameter int unsigned MAX_LEVELS = 4,
  parameter int unsigned FRAME_BITS = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [31:0] logical_addr_i,
  input  wire logic [19:0] fill_frame_i,
  input  wire logic        fill_error_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [35:0]      physical_addr_o,
  output logic [19:0]      frame_number_o,
  output logic [27:0]      page_number_o,
  output logic [63:0]      walk_indices_o
);
  localparam int unsigned IdxW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TLB_DEPTH + 1);
  localparam int unsigned EntW = tlb_tf_pkg::PageW + tlb_tf_pkg::PidW + FRAME_BITS
                                 + 2 * tlb_tf_pkg::StampW;

  // Configuration registers.
  logic [15:0] pid_q;
  logic [4:0]  in_use_q, psl_q, tel_q;
  logic        policy_q;
  logic [2:0]  levels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_q <= '0; in_use_q <= 5'd16; policy_q <= 1'b0;
      psl_q <= 5'd6; tel_q <= 5'd2; levels_q <= 3'd3;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tlb_tf_pkg::RegPid:    pid_q    <= cfg_data_i;
        tlb_tf_pkg::RegInUse:  in_use_q <= cfg_data_i[4:0];
        tlb_tf_pkg::RegPolicy: policy_q <= cfg_data_i[0];
        tlb_tf_pkg::RegPsl:    psl_q    <= cfg_data_i[4:0];
        tlb_tf_pkg::RegTel:    tel_q    <= cfg_data_i[4:0];
        tlb_tf_pkg::RegLevels: levels_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Saturated configuration.
  logic [4:0]    psl, tel;
  logic [2:0]    lv;
  logic [CntW:0] n_ext;
  logic [CntW-1:0] n;
  always_comb begin
    psl = (psl_q < 5'd4) ? 5'd4 : ((psl_q > 5'd16) ? 5'd16 : psl_q);
    tel = (tel_q < 5'd1) ? 5'd1 : ((tel_q > 5'd16) ? 5'd16 : tel_q);
    lv  = (levels_q < 3'd1) ? 3'd1 :
          ((32'(levels_q) > MAX_LEVELS) ? 3'(MAX_LEVELS) : levels_q);
    n_ext = (CntW + 1)'(in_use_q);
    n = (32'(in_use_q) > TLB_DEPTH) ? CntW'(TLB_DEPTH) : n_ext[CntW-1:0];
  end

  // Entry memory plus valid bits.
  logic [TLB_DEPTH-1:0] valid_q;
  logic              we;
  logic [IdxW-1:0]   waddr, raddr;
  logic [EntW-1:0]   wdata, rdata;

  tlb_tf_ram #(.Width(EntW), .Depth(TLB_DEPTH)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [27:0] e_page; logic [15:0] e_pid; logic [FRAME_BITS-1:0] e_frame;
  logic [31:0] e_cre, e_used;
  assign {e_page, e_pid, e_frame, e_cre, e_used} = rdata;

  // Item state.
  tlb_tf_pkg::state_e state_q;
  logic        type_q;
  logic [27:0] page_q; logic [15:0] off_q;
  logic [FRAME_BITS-1:0] fframe_q;
  logic [CntW-1:0] cnt_q;      // slot whose read is issued
  logic [IdxW-1:0] rd_q;       // slot whose data is in rdata
  logic        rd_vld_q;
  logic        found_q, empty_f_q;
  logic [IdxW-1:0] slot_q, empty_q, best_q;
  logic [31:0] best_st_q;
  logic [31:0] stamp_q;
  logic        pend_q; logic [27:0] ppage_q; logic [15:0] poff_q;
  logic [2:0]  st_q; logic [35:0] pa_q; logic [19:0] fn_q; logic [27:0] pn_q;
  logic [63:0] wi_q;
  logic        ov_q;

  logic [27:0] cur_page; logic [15:0] cur_off;
  logic [35:0] off_mask;
  assign off_mask = (36'd1 << psl) - 36'd1;
  assign cur_page = 28'((logical_addr_i >> psl));
  assign cur_off  = 16'(32'(logical_addr_i) & 32'(off_mask));

  // Walk index packing over at most four levels.
  function automatic logic [63:0] pack(input logic [27:0] pg, input logic [4:0] t,
                                       input logic [2:0] l);
    logic [63:0] p; logic [15:0] m; logic [27:0] ix; logic [7:0] sh;
    p = '0;
    m = 16'((17'd1 << t) - 17'd1);
    for (int x = 1; x <= 4; x++) begin
      if (3'(x) <= l) begin
        sh = 8'(t * 5'(l - 3'(x)));
        ix = (sh >= 8'd28) ? 28'd0 : (pg >> sh);
        p = p | (64'(ix[15:0] & m) << (16 * (l - 3'(x))));
      end
    end
    return p;
  endfunction

  logic in_acc, hit_now, match_fill, rd_in_range;
  assign in_stall_o  = (state_q != tlb_tf_pkg::S_IDLE) || ov_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign rd_in_range = rd_vld_q && valid_q[rd_q];
  assign hit_now     = rd_in_range && e_page == page_q && e_pid == pid_q;
  assign match_fill  = rd_in_range && e_frame == fframe_q && e_pid == pid_q;

  // On a hit the hit slot is read again so its fields are on hand for the
  // write-back of the use stamp.
  always_comb begin
    if (state_q == tlb_tf_pkg::S_SCAN && type_q == 1'b0 && hit_now)
      raddr = rd_q;
    else
      raddr = cnt_q[IdxW-1:0];
    we    = (state_q == tlb_tf_pkg::S_WRITE);
    waddr = slot_q;
    if (type_q == 1'b0)
      wdata = {e_page, e_pid, e_frame, e_cre, stamp_q};
    else
      wdata = {ppage_q, pid_q, fframe_q, stamp_q, stamp_q};
  end

  logic [31:0] vict_st;
  assign vict_st = policy_q ? e_used : e_cre;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlb_tf_pkg::S_IDLE; valid_q <= '0; stamp_q <= '0;
      pend_q <= 1'b0; ov_q <= 1'b0; rd_vld_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (state_q)
        tlb_tf_pkg::S_IDLE: begin
          rd_vld_q <= 1'b0; found_q <= 1'b0; empty_f_q <= 1'b0;
          best_st_q <= '1; best_q <= '0; cnt_q <= '0;
          if (in_acc) begin
            type_q <= req_type_i;
            page_q <= cur_page; off_q <= cur_off;
            fframe_q <= FRAME_BITS'(fill_frame_i);
            if (req_type_i && !pend_q) begin
              st_q <= tlb_tf_pkg::StNoPending; pa_q <= '0; fn_q <= '0;
              pn_q <= '0; wi_q <= '0; ov_q <= 1'b1;
            end else if (req_type_i && fill_error_i) begin
              pend_q <= 1'b0;
              st_q <= tlb_tf_pkg::StWalkErr; pa_q <= '0; fn_q <= '0;
              pn_q <= ppage_q; wi_q <= '0; ov_q <= 1'b1;
            end else begin
              state_q <= tlb_tf_pkg::S_SCAN;
            end
          end
        end
        tlb_tf_pkg::S_SCAN: begin
          // Issue read of slot cnt_q; evaluate previous slot's data.
          rd_q <= cnt_q[IdxW-1:0];
          rd_vld_q <= (cnt_q < n) && !(type_q == 1'b0 && hit_now);
          if (cnt_q < n) cnt_q <= cnt_q + 1'b1;
          if (type_q == 1'b0 && hit_now) begin
            slot_q <= rd_q;
            st_q <= tlb_tf_pkg::StHit;
            pa_q <= ((36'(e_frame) << psl) | 36'(off_q)) & 36'hF_FFFF_FFFF;
            fn_q <= 20'(e_frame); pn_q <= page_q; wi_q <= '0;
            state_q <= tlb_tf_pkg::S_WRITE;
          end else if (type_q && rd_vld_q) begin
            if (match_fill && !found_q) begin found_q <= 1'b1; slot_q <= rd_q; end
            if (!valid_q[rd_q] && !empty_f_q) begin
              empty_f_q <= 1'b1; empty_q <= rd_q;
            end
            if (valid_q[rd_q] && (rd_q == '0 || vict_st < best_st_q)) begin
              best_st_q <= vict_st; best_q <= rd_q;
            end
          end
          if (!rd_vld_q && !(cnt_q < n) && !(type_q == 1'b0 && hit_now)) begin
            if (type_q == 1'b0) begin
              pend_q <= 1'b1; ppage_q <= page_q; poff_q <= off_q;
              st_q <= tlb_tf_pkg::StMiss; pa_q <= '0; fn_q <= '0;
              pn_q <= page_q; wi_q <= pack(page_q, tel, lv);
              state_q <= tlb_tf_pkg::S_OUT;
            end else begin
              state_q <= tlb_tf_pkg::S_PICK;
            end
          end
        end
        tlb_tf_pkg::S_PICK: begin
          pend_q <= 1'b0;
          st_q <= tlb_tf_pkg::StFilled;
          pa_q <= ((36'(fframe_q) << psl) | (36'(poff_q) & off_mask))
                  & 36'hF_FFFF_FFFF;
          fn_q <= 20'(fframe_q); pn_q <= ppage_q; wi_q <= '0;
          if (!found_q) slot_q <= empty_f_q ? empty_q : best_q;
          state_q <= (n == '0) ? tlb_tf_pkg::S_OUT : tlb_tf_pkg::S_WRITE;
        end
        tlb_tf_pkg::S_WRITE: begin
          valid_q[slot_q] <= 1'b1;
          stamp_q <= stamp_q + 32'd1;
          state_q <= tlb_tf_pkg::S_OUT;
        end
        tlb_tf_pkg::S_OUT: begin
          ov_q <= 1'b1;
          state_q <= tlb_tf_pkg::S_IDLE;
        end
        default: state_q <= tlb_tf_pkg::S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = ov_q;
  assign status_o        = st_q;
  assign physical_addr_o = pa_q;
  assign frame_number_o  = fn_q;
  assign page_number_o   = pn_q;
  assign walk_indices_o  = wi_q;
endmodule : tlb_translate_fifo_lru_unit
`default_nettype wire

[rtl/tlb_tf_ram.sv]
// ----------------------------------------------------------------------------
// TLB generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module tlb_tf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule : tlb_tf_ram
`default_nettype wire

[rtl/tlb_tf_checker.sv]
// ----------------------------------------------------------------------------
// TLB port checker
// Watches the ports of the translate unit over time.
// ----------------------------------------------------------------------------
`default_nettype none
module tlb_tf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  status_o,
  input wire logic [63:0] walk_indices_o
);
  // A held result stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result changed while stalled");
  // Status is a defined code.
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= tlb_tf_pkg::StNoPending) else $error("bad status");
  // Walk indices only on a miss.
  a_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != tlb_tf_pkg::StMiss |-> walk_indices_o == 64'd0)
    else $error("walk indices outside miss");
  // No item taken while a result waits.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accepted while result pending");
  // An accepted item blocks the input next cycle.
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("no stall after accept");
endmodule : tlb_tf_checker

bind tlb_translate_fifo_lru_unit tlb_tf_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .status_o, .walk_indices_o
);
`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// TLB translate unit testbench
// Drives translate and fill items with random idling and a long output hold,
// predicts each result with a software copy of the TLB and compares fields.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [35:0] phys;
    logic [19:0] frame;
    logic [27:0] page;
    logic [63:0] walk;
  } xlate_res_t;

  // Scoreboard: software TLB plus the queue of expected results.
  class tlb_scoreboard;
    logic [15:0] pid;
    logic [4:0]  in_use, psl_reg, tel_reg;
    logic        policy;
    logic [2:0]  levels_reg;
    logic        ent_valid[Depth];
    logic [27:0] ent_page[Depth];
    logic [15:0] ent_pid[Depth];
    logic [19:0] ent_frame[Depth];
    logic [31:0] ent_created[Depth];
    logic [31:0] ent_used[Depth];
    logic [31:0] stamp;
    logic        pend_valid;
    logic [27:0] pend_page;
    logic [15:0] pend_off;
    xlate_res_t  expected_q[$];
    int          errors;

    function new();
      pid = 0; in_use = 16; policy = 0; psl_reg = 6; tel_reg = 2; levels_reg = 3;
      for (int i = 0; i < Depth; i++) begin
        ent_valid[i] = 0; ent_page[i] = 0; ent_pid[i] = 0; ent_frame[i] = 0;
        ent_created[i] = 0; ent_used[i] = 0;
      end
      stamp = 0; pend_valid = 0; pend_page = 0; pend_off = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        tlb_tf_pkg::RegPid:    pid = val;
        tlb_tf_pkg::RegInUse:  in_use = val[4:0];
        tlb_tf_pkg::RegPolicy: policy = val[0];
        tlb_tf_pkg::RegPsl:    psl_reg = val[4:0];
        tlb_tf_pkg::RegTel:    tel_reg = val[4:0];
        tlb_tf_pkg::RegLevels: levels_reg = val[2:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] walk_of(logic [27:0] pg);
      int t, lv;
      logic [63:0] packed_idx, m;
      t = tel_reg < 1 ? 1 : (tel_reg > 16 ? 16 : tel_reg);
      lv = levels_reg < 1 ? 1 : (levels_reg > 4 ? 4 : levels_reg);
      m = (64'd1 << t) - 1;
      packed_idx = 0;
      for (int x = 1; x <= lv; x++)
        packed_idx |= (((64'(pg)) >> (t * (lv - x))) & m) << (16 * (lv - x));
      return packed_idx;
    endfunction

    function int choose_slot(logic [19:0] fr, int n);
      int best;
      logic [31:0] a, b;
      best = 0;
      for (int i = 0; i < n; i++)
        if (ent_valid[i] && ent_frame[i] == fr && ent_pid[i] == pid) return i;
      for (int i = 0; i < n; i++)
        if (!ent_valid[i]) return i;
      for (int i = 1; i < n; i++) begin
        a = policy ? ent_used[i] : ent_created[i];
        b = policy ? ent_used[best] : ent_created[best];
        if (a < b) best = i;
      end
      return best;
    endfunction

    // Work out the result of one accepted item and queue it.
    function void note_item(logic rtype, logic [31:0] addr, logic [19:0] fr, logic ferr);
      int psl, n, slot;
      logic [27:0] pg;
      logic [15:0] off;
      xlate_res_t r;
      psl = psl_reg < 4 ? 4 : (psl_reg > 16 ? 16 : psl_reg);
      n = in_use > Depth ? Depth : in_use;
      r = '0;
      if (!rtype) begin
        pg = 28'(addr >> psl);
        off = 16'(addr & ((32'd1 << psl) - 1));
        r.page = pg;
        for (int i = 0; i < n; i++) begin
          if (ent_valid[i] && ent_page[i] == pg && ent_pid[i] == pid) begin
            ent_used[i] = stamp; stamp++;
            r.status = tlb_tf_pkg::StHit;
            r.phys = 36'((36'(ent_frame[i]) << psl) | off);
            r.frame = ent_frame[i];
            expected_q.push_back(r);
            return;
          end
        end
        pend_valid = 1; pend_page = pg; pend_off = off;
        r.status = tlb_tf_pkg::StMiss;
        r.walk = walk_of(pg);
      end else if (!pend_valid) begin
        r.status = tlb_tf_pkg::StNoPending;
      end else begin
        r.page = pend_page;
        pend_valid = 0;
        if (ferr) r.status = tlb_tf_pkg::StWalkErr;
        else begin
          if (n > 0) begin
            slot = choose_slot(fr, n);
            ent_valid[slot] = 1; ent_page[slot] = pend_page; ent_pid[slot] = pid;
            ent_frame[slot] = fr; ent_created[slot] = stamp; ent_used[slot] = stamp;
            stamp++;
          end
          r.status = tlb_tf_pkg::StFilled;
          r.phys = 36'((36'(fr) << psl) | (pend_off & ((32'd1 << psl) - 1)));
          r.frame = fr;
        end
      end
      expected_q.push_back(r);
    endfunction

    task check_result(xlate_res_t got);
      xlate_res_t e;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no item outstanding", 64'd0, 64'd0);
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status)
        report_mismatch("status", 64'(got.status), 64'(e.status));
      if (got.phys !== e.phys)
        report_mismatch("physical_addr", 64'(got.phys), 64'(e.phys));
      if (got.frame !== e.frame)
        report_mismatch("frame_number", 64'(got.frame), 64'(e.frame));
      if (got.page !== e.page)
        report_mismatch("page_number", 64'(got.page), 64'(e.page));
      if (got.walk !== e.walk) report_mismatch("walk_indices", got.walk, e.walk);
    endtask

    task report_mismatch(string what, logic [63:0] got, logic [63:0] exp_v);
      errors++;
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic        req_type_i = 0;
  logic [31:0] logical_addr_i = '0;
  logic [19:0] fill_frame_i = '0;
  logic        fill_error_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [2:0]  status_o;
  logic [35:0] physical_addr_o;
  logic [19:0] frame_number_o;
  logic [27:0] page_number_o;
  logic [63:0] walk_indices_o;

  tlb_scoreboard sb = new();
  bit calm = 0;          // no idling on either side
  int hold_cycles = 0;   // receiver hold-off still to run
  logic [31:0] recent_addr[$];

  tlb_translate_fifo_lru_unit uut (.*);

  always #1 clk_i = ~clk_i;

  // Receiver: random stall, occasional long hold, check every taken result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({status_o, physical_addr_o, frame_number_o, page_number_o,
                       walk_indices_o});
  end
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1;
    end else out_stall_i <= !calm && ($urandom_range(99) < 23);
  end

  task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.write_reg(idx, val);
  endtask

  // Offer one item, with a random gap before it, and wait until accepted.
  task automatic send_item(logic rtype, logic [31:0] addr, logic [19:0] fr, logic ferr);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1; req_type_i <= rtype; logical_addr_i <= addr;
    fill_frame_i <= fr; fill_error_i <= ferr;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(rtype, addr, fr, ferr);
    if (!rtype) begin
      recent_addr.push_back(addr);
      if (recent_addr.size() > 24) void'(recent_addr.pop_front());
    end
    @(negedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 0;
    while (sb.expected_q.size() != 0 && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (30) @(negedge clk_i);
  endtask

  task automatic random_addr(output logic [31:0] a);
    if (recent_addr.size() > 0 && $urandom_range(99) < 55) begin
      a = recent_addr[$urandom_range(recent_addr.size() - 1)];
      if ($urandom_range(1)) a = a ^ 32'($urandom_range(15));
    end else if ($urandom_range(1)) a = $urandom;
    else a = 32'($urandom_range(4095)) << $urandom_range(20);
  endtask

  // One miss/fill round trip with random content, or noise.
  task automatic random_step();
    logic [31:0] a;
    logic [19:0] fr;
    random_addr(a);
    fr = ($urandom_range(3) == 0) ? 20'($urandom_range(31)) : 20'($urandom);
    if ($urandom_range(9) < 7) begin
      send_item(0, a, 20'($urandom), 1'($urandom_range(1)));
      if (sb.pend_valid && $urandom_range(9) < 8)
        send_item(1, $urandom, fr, $urandom_range(15) == 0);
    end else send_item(1, $urandom, fr, $urandom_range(3) == 0);
  endtask

  task automatic set_config(int ph);
    cfg_write(tlb_tf_pkg::RegPid, (ph % 3 == 2) ? 16'hFFFF : 16'($urandom_range(3)));
    cfg_write(tlb_tf_pkg::RegInUse, (ph == 1) ? 16'd0 : (ph == 2) ? 16'd31 :
              16'($urandom_range(1, 16)));
    cfg_write(tlb_tf_pkg::RegPolicy, 16'(ph % 2));
    cfg_write(tlb_tf_pkg::RegPsl, (ph == 2) ? 16'd16 : (ph == 3) ? 16'd4 :
              (ph == 4) ? 16'd0 : (ph == 5) ? 16'd31 : 16'($urandom_range(4, 16)));
    cfg_write(tlb_tf_pkg::RegTel, (ph == 2) ? 16'd16 : (ph == 3) ? 16'd1 :
              (ph == 4) ? 16'd0 : (ph == 5) ? 16'd31 : 16'($urandom_range(1, 16)));
    cfg_write(tlb_tf_pkg::RegLevels, (ph == 2) ? 16'd4 : (ph == 3) ? 16'd1 :
              (ph == 4) ? 16'd0 : (ph == 5) ? 16'd7 : 16'($urandom_range(1, 4)));
  endtask

  // Stimulus and final verdict.
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: reset configuration, extremes, every status.
    send_item(1, 0, 0, 0);                      // fill with nothing pending
    send_item(0, 32'hFFFFFFFF, 0, 0);           // miss
    send_item(1, 0, 20'hFFFFF, 0);              // fill
    send_item(0, 32'hFFFFFFFF, 0, 0);           // hit
    send_item(0, 32'h0, 0, 0);                  // miss
    send_item(0, 32'h12345678, 0, 0);           // miss replaces pending
    send_item(1, 0, 20'hFFFFF, 0);              // same frame: overwrite
    send_item(0, 32'h0, 0, 0);
    send_item(1, 0, 0, 1);                      // walk error
    send_item(1, 0, 0, 0);                      // nothing pending after error
    for (int i = 0; i < 5; i++) begin
      send_item(0, 32'(i) << 20, 0, 0);
      send_item(1, 0, 20'(i + 1), 0);
    end
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_config(ph);
      calm = (ph == 6);
      if (ph == 3) begin
        fork
          begin @(negedge clk_i); hold_cycles <= 150; end
          repeat (20) random_step();
        join
      end
      repeat (150) random_step();
      drain();
    end
    calm = 0;

    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
